// ===== rtl/mps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants of the round-robin poll scheduler: opcodes,
// register indexes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Input opcodes.
  localparam logic OP_POLL     = 1'b0;
  localparam logic OP_SET_FLAG = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_FUNCTION_CODE = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_START_ADDR_A  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_WORD_COUNT_A  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_START_ADDR_B  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_WORD_COUNT_B  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_START_ADDR_C  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_WORD_COUNT_C  = 3'd6;

  // Request groups.
  localparam logic [1:0] GROUP_A = 2'd0;
  localparam logic [1:0] GROUP_B = 2'd1;
  localparam logic [1:0] GROUP_C = 2'd2;
  localparam logic [1:0] GROUP_WRAP = 2'd3;

  localparam logic [1:0] MISS_LIMIT    = 2'd3;
  localparam logic [3:0] BACKOFF_LIMIT = 4'd10;

  localparam logic [7:0] FUNCTION_CODE_RESET = 8'd3;
  localparam logic [6:0] WORD_COUNT_RESET    = 7'd1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } mps_state_t;

  typedef struct packed {
    logic start;    // wrap the walk position at the start of a poll
    logic flag_wr;  // write one slave's active flag
    logic step;     // handle the current slave
  } mps_cmd_t;

  typedef struct packed {
    logic at_end;   // walk has run past the last slave
    logic skip;     // current slave is in backoff
    logic out_free; // result register can take a new item
  } mps_status_t;

endpackage
`default_nettype wire

// ===== rtl/mps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mps_ctrl
// Controller of the poll scheduler: accepts items and steps the datapath
// through the slave walk, one slave per cycle unless a request is stalled.
// ----------------------------------------------------------------------------
module mps_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  opcode,
  output logic                 in_ready,
  input  mps_pkg::mps_status_t status,
  output mps_pkg::mps_cmd_t    cmd
);
  import mps_pkg::*;

  mps_state_t state;
  mps_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && opcode == OP_POLL) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.at_end) begin
          state_next = ST_IDLE;
        end else if (!status.skip && status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.flag_wr = 1'b0;
    cmd.step    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.start   = in_valid && opcode == OP_POLL;
        cmd.flag_wr = in_valid && opcode == OP_SET_FLAG;
      end
      ST_WALK: begin
        // A slave due a request waits until the result register is free.
        cmd.step = !status.at_end && (status.skip || status.out_free);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mps_datapath
// Datapath of the poll scheduler: configuration registers, walk position,
// per-slave active flags and miss/backoff counters, and the result register.
// ----------------------------------------------------------------------------
module mps_datapath #(
  parameter int NUM_SLAVES = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_wr_en,
  input  wire  [mps_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire  [mps_pkg::CfgDataWidth-1:0]      cfg_data,
  input  wire  [3:0]                            slave_index,
  input  wire                                   active_value,
  input  mps_pkg::mps_cmd_t                     cmd,
  output mps_pkg::mps_status_t                  status,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [4:0]                            slave_address,
  output logic [7:0]                            request_function,
  output logic [15:0]                           start_address,
  output logic [6:0]                            word_count,
  output logic [1:0]                            group_index
);
  import mps_pkg::*;

  localparam int SW = $clog2(NUM_SLAVES + 1);
  localparam int IW = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;

  logic [7:0]  function_code;
  logic [15:0] start_addr_a;
  logic [15:0] start_addr_b;
  logic [15:0] start_addr_c;
  logic [6:0]  word_count_a;
  logic [6:0]  word_count_b;
  logic [6:0]  word_count_c;

  logic [SW-1:0] cur_slave;
  logic [1:0]    cur_group;

  logic       slave_active [NUM_SLAVES];
  logic [1:0] miss_count   [NUM_SLAVES];
  logic [3:0] backoff_count[NUM_SLAVES];

  logic [IW-1:0] cur_idx;
  logic [IW-1:0] flag_idx;
  logic          flag_in_range;
  logic [1:0]    cur_miss;
  logic [3:0]    backoff_inc;
  logic          emit;
  logic [SW-1:0] addr_sum;
  logic [15:0]   sel_start;
  logic [6:0]    sel_count;

  assign cur_idx       = cur_slave[IW-1:0];
  assign flag_idx      = IW'(slave_index);
  assign flag_in_range = 32'(slave_index) < NUM_SLAVES;
  assign cur_miss      = miss_count[cur_idx];
  assign backoff_inc   = backoff_count[cur_idx] + 4'd1;
  // Only used while the walk is on a real slave, so the sum never exceeds NUM_SLAVES.
  assign addr_sum      = cur_slave + SW'(1);

  assign status.at_end   = 32'(cur_slave) >= NUM_SLAVES;
  assign status.skip     = cur_miss == MISS_LIMIT;
  assign status.out_free = !out_valid || out_ready;

  assign emit = cmd.step && !status.skip;

  always_comb begin
    case (cur_group)
      GROUP_B: begin
        sel_start = start_addr_b;
        sel_count = word_count_b;
      end
      GROUP_C: begin
        sel_start = start_addr_c;
        sel_count = word_count_c;
      end
      default: begin
        sel_start = start_addr_a;
        sel_count = word_count_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      function_code <= FUNCTION_CODE_RESET;
      start_addr_a  <= '0;
      start_addr_b  <= '0;
      start_addr_c  <= '0;
      word_count_a  <= WORD_COUNT_RESET;
      word_count_b  <= WORD_COUNT_RESET;
      word_count_c  <= WORD_COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FUNCTION_CODE: function_code <= cfg_data[7:0];
        REG_START_ADDR_A:  start_addr_a  <= cfg_data;
        REG_WORD_COUNT_A:  word_count_a  <= cfg_data[6:0];
        REG_START_ADDR_B:  start_addr_b  <= cfg_data;
        REG_WORD_COUNT_B:  word_count_b  <= cfg_data[6:0];
        REG_START_ADDR_C:  start_addr_c  <= cfg_data;
        REG_WORD_COUNT_C:  word_count_c  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Walk position. A poll starts by wrapping a position left at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slave <= '0;
      cur_group <= GROUP_A;
    end else if (cmd.start) begin
      if (status.at_end) begin
        cur_slave <= '0;
      end
      if (cur_group == GROUP_WRAP) begin
        cur_group <= GROUP_A;
      end
    end else if (cmd.step) begin
      if (status.skip) begin
        cur_slave <= addr_sum;
      end else if (cur_group == GROUP_C) begin
        cur_group <= GROUP_A;
        cur_slave <= addr_sum;
      end else begin
        cur_group <= cur_group + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLAVES; i++) begin
        slave_active[i]  <= 1'b0;
        miss_count[i]    <= '0;
        backoff_count[i] <= '0;
      end
    end else begin
      if (cmd.flag_wr && flag_in_range) begin
        slave_active[flag_idx] <= active_value;
      end
      if (cmd.step) begin
        if (status.skip) begin
          // Backoff runs out at the limit and the slave is polled again.
          if (backoff_inc >= BACKOFF_LIMIT) begin
            backoff_count[cur_idx] <= '0;
            miss_count[cur_idx]    <= '0;
          end else begin
            backoff_count[cur_idx] <= backoff_inc;
          end
        end else if (!slave_active[cur_idx]) begin
          miss_count[cur_idx] <= cur_miss + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      slave_address    <= 5'(addr_sum);
      request_function <= function_code;
      start_address    <= sel_start;
      word_count       <= sel_count;
      group_index      <= cur_group;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/modbus_poll_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_poll_scheduler
// Round-robin master poller: three read-request groups per slave, with
// miss counting and backoff of slaves that stop answering.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  -------------------------------------------
//  input    in_valid / in_ready     opcode, slave_index, active_value
//  result   out_valid / out_ready   slave_address, request_function,
//                                   start_address, word_count, group_index
//  config   cfg_wr_en (no wait)     cfg_index, cfg_data
//
// A set-flag item is taken while idle. A poll item is accepted, then the walk
// passes over slaves in backoff until it issues one request or runs past the
// last slave, one slave per cycle unless stalled. Reset is synchronous and
// clears all per-slave state at once. A finished result waits in the output
// register; the walk stalls only on a new request while that register is full.
//
module modbus_poll_scheduler #(
  parameter int NUM_SLAVES = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [mps_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire  [mps_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               opcode,
  input  wire  [3:0]                        slave_index,
  input  wire                               active_value,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [4:0]                        slave_address,
  output logic [7:0]                        request_function,
  output logic [15:0]                       start_address,
  output logic [6:0]                        word_count,
  output logic [1:0]                        group_index
);
  import mps_pkg::*;

  mps_cmd_t    cmd;
  mps_status_t status;

  mps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mps_datapath #(
    .NUM_SLAVES (NUM_SLAVES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .slave_index      (slave_index),
    .active_value     (active_value),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slave_address    (slave_address),
    .request_function (request_function),
    .start_address    (start_address),
    .word_count       (word_count),
    .group_index      (group_index)
  );

  // A poll item starts a walk, so nothing further is taken in the next cycle.
  a_poll_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_POLL) |=> !in_ready)
    else $error("input accepted during a poll walk");

  // A result never carries the unused group code.
  a_group_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> group_index != GROUP_WRAP)
    else $error("result carries an invalid group");

  // A request is issued only while a walk is running, never on a set-flag item.
  a_emit_from_walk: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> $past(!in_ready))
    else $error("result appeared outside a poll walk");

endmodule
`default_nettype wire

// ===== test/tb_modbus_poll_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_modbus_poll_scheduler
// Self-checking bench for the round-robin poll scheduler. Poll ticks and
// active-flag writes go in under random idling and back-pressure. A scoreboard
// tracks the walk, the miss and backoff counters and the register settings,
// and it checks every request that comes out, field by field and in order.
// ----------------------------------------------------------------------------
module tb_modbus_poll_scheduler;
  import mps_pkg::*;

  localparam int NUM_SLAVES     = 16;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = NUM_SLAVES + 4;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int PHASE_ITEMS    = 255;
  localparam int MAX_PRINTS     = 40;

  // The package names only the seven real registers; this one does not exist.
  localparam logic [CfgIndexWidth-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [4:0]  slave_address;
    logic [7:0]  request_function;
    logic [15:0] start_address;
    logic [6:0]  word_count;
    logic [1:0]  group_index;
  } poll_req_t;

  class poll_scoreboard;
    logic [7:0]  func_code;
    logic [15:0] group_addr[3];
    logic [6:0]  group_words[3];
    int          walk_slave;
    logic [1:0]  walk_group;
    logic        active[NUM_SLAVES];
    logic [1:0]  misses[NUM_SLAVES];
    logic [3:0]  backoff[NUM_SLAVES];
    poll_req_t   requests_due[$];
    int          errors;
    int          requests_seen;
    int          empty_walks;
    int          releases;

    function void clear();
      func_code  = FUNCTION_CODE_RESET;
      for (int g = 0; g < 3; g++) begin
        group_addr[g]  = '0;
        group_words[g] = WORD_COUNT_RESET;
      end
      walk_slave = 0;
      walk_group = GROUP_A;
      for (int s = 0; s < NUM_SLAVES; s++) begin
        active[s]  = 1'b0;
        misses[s]  = '0;
        backoff[s] = '0;
      end
      requests_due.delete();
      errors = 0;
      requests_seen = 0;
      empty_walks = 0;
      releases = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_FUNCTION_CODE: func_code = data[7:0];
        REG_START_ADDR_A:  group_addr[0] = data;
        REG_WORD_COUNT_A:  group_words[0] = data[6:0];
        REG_START_ADDR_B:  group_addr[1] = data;
        REG_WORD_COUNT_B:  group_words[1] = data[6:0];
        REG_START_ADDR_C:  group_addr[2] = data;
        REG_WORD_COUNT_C:  group_words[2] = data[6:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic op, logic [3:0] idx, logic val);
      poll_req_t req;
      int s;
      if (op == OP_SET_FLAG) begin
        if (idx < NUM_SLAVES) active[idx] = val;
        return;
      end
      if (walk_slave >= NUM_SLAVES) walk_slave = 0;
      if (walk_group == GROUP_WRAP) walk_group = GROUP_A;
      while (walk_slave < NUM_SLAVES) begin
        s = walk_slave;
        if (misses[s] == MISS_LIMIT) begin
          // Slave in backoff: counted and passed over.
          backoff[s] = backoff[s] + 4'd1;
          if (backoff[s] >= BACKOFF_LIMIT) begin
            misses[s]  = '0;
            backoff[s] = '0;
            releases++;
          end
          walk_slave++;
        end else begin
          if (!active[s]) misses[s] = misses[s] + 2'd1;
          req.slave_address    = 5'(s + 1);
          req.request_function = func_code;
          req.start_address    = group_addr[walk_group];
          req.word_count       = group_words[walk_group];
          req.group_index      = walk_group;
          requests_due.push_back(req);
          walk_group = walk_group + 2'd1;
          if (walk_group == GROUP_WRAP) begin
            walk_group = GROUP_A;
            walk_slave = s + 1;
          end
          return;
        end
      end
      // The walk ran off the end; the group position is left as it was.
      empty_walks++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("request %0d %s: got %0d, expected %0d",
                         requests_seen, name, got, want));
    endtask

    task check_result(poll_req_t got);
      poll_req_t want;
      if (requests_due.size() == 0) begin
        report($sformatf("unexpected request to slave %0d group %0d",
                         got.slave_address, got.group_index));
        return;
      end
      want = requests_due.pop_front();
      compare_field("slave_address", got.slave_address, want.slave_address);
      compare_field("request_function", got.request_function, want.request_function);
      compare_field("start_address", got.start_address, want.start_address);
      compare_field("word_count", got.word_count, want.word_count);
      compare_field("group_index", got.group_index, want.group_index);
      requests_seen++;
    endtask

    function int pending();
      return requests_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     opcode = OP_POLL;
  logic [3:0]               slave_index = '0;
  logic                     active_value = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [4:0]               slave_address;
  logic [7:0]               request_function;
  logic [15:0]              start_address;
  logic [6:0]               word_count;
  logic [1:0]               group_index;

  poll_scoreboard sb;
  int  items_sent = 0;
  int  config_sets = 0;
  bit  tx_calm = 1'b0;
  int  tx_mode_left = 0;
  bit  rx_calm = 1'b0;
  int  rx_mode_left = 0;
  int  rx_gap = 0;
  bit  rx_long_hold = 1'b0;

  modbus_poll_scheduler #(.NUM_SLAVES(NUM_SLAVES)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slave_index(slave_index), .active_value(active_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .slave_address(slave_address), .request_function(request_function),
    .start_address(start_address), .word_count(word_count),
    .group_index(group_index)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, calm stretches, and a long hold on request.
  always @(posedge clk) begin
    if (rx_long_hold) begin
      rx_gap = LONG_HOLD;
      rx_long_hold = 1'b0;
    end
    if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
      if (rx_mode_left == 0) begin
        rx_calm = ($urandom_range(0, 2) == 0);
        rx_mode_left = $urandom_range(50, 200);
      end else begin
        rx_mode_left--;
      end
      if (!rx_calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    poll_req_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(opcode, slave_index, active_value);
      if (out_valid && out_ready) begin
        got.slave_address    = slave_address;
        got.request_function = request_function;
        got.start_address    = start_address;
        got.word_count       = word_count;
        got.group_index      = group_index;
        sb.check_result(got);
      end
    end
  end

  // Returns in the time step of acceptance, or after a gap with in_valid low;
  // the caller must drive the channel again in that same step.
  task automatic send_item(input logic op, input logic [3:0] idx, input logic val);
    int gap;
    in_valid     <= 1'b1;
    opcode       <= op;
    slave_index  <= idx;
    active_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (tx_mode_left == 0) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      tx_mode_left = $urandom_range(30, 100);
    end else begin
      tx_mode_left--;
    end
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for every outstanding request; with settle set, also lets a poll
  // that yields nothing finish its walk.
  task automatic wait_for_requests(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] fc,
                             input logic [15:0] addr_a, input logic [6:0] words_a,
                             input logic [15:0] addr_b, input logic [6:0] words_b,
                             input logic [15:0] addr_c, input logic [6:0] words_c);
    write_reg(REG_FUNCTION_CODE, {8'd0, fc});
    write_reg(REG_START_ADDR_A, addr_a);
    write_reg(REG_WORD_COUNT_A, {9'd0, words_a});
    write_reg(REG_START_ADDR_B, addr_b);
    write_reg(REG_WORD_COUNT_B, {9'd0, words_b});
    write_reg(REG_START_ADDR_C, addr_c);
    write_reg(REG_WORD_COUNT_C, {9'd0, words_c});
    // A write to the unmapped index must leave everything above untouched.
    write_reg(REG_UNMAPPED, 16'($urandom()));
    cfg_wr_en <= 1'b0;
    config_sets++;
  endtask

  task automatic load_random_config();
    load_config(8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 7'($urandom_range(0, 125)),
                16'($urandom_range(0, 65535)), 7'($urandom_range(0, 125)),
                16'($urandom_range(0, 65535)), 7'($urandom_range(0, 125)));
  endtask

  task automatic run_directed();
    // First slave is inactive: its three groups go out and it falls into backoff.
    repeat (3) send_item(OP_POLL, 4'd0, 1'b0);
    send_item(OP_SET_FLAG, 4'd1, 1'b1);
    send_item(OP_SET_FLAG, 4'd15, 1'b1);
    send_item(OP_SET_FLAG, 4'd0, 1'b1);
    // Fields that a poll tick does not use are driven to arbitrary values, not all zero.
    send_item(OP_POLL, 4'd15, 1'b1);
    send_item(OP_POLL, 4'd9, 1'b0);
    send_item(OP_POLL, 4'd0, 1'b1);
    send_item(OP_SET_FLAG, 4'd5, 1'b1);
    send_item(OP_SET_FLAG, 4'd5, 1'b0);
    send_item(OP_SET_FLAG, 4'd10, 1'b1);
    repeat (10) send_item(OP_POLL, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int n, input int flag_pct, input int active_pct,
                           input int hold_at, input int pause_at);
    logic op;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) rx_long_hold = 1'b1;
      if (i == pause_at) wait_for_requests(1'b0);
      op = ($urandom_range(0, 99) < flag_pct) ? OP_SET_FLAG : OP_POLL;
      send_item(op, 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 99) < active_pct));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers left at their reset values for the directed part.
    run_directed();
    wait_for_requests(1'b1);

    load_config(8'd0, 16'd0, 7'd0, 16'd0, 7'd0, 16'd0, 7'd0);
    run_phase(PHASE_ITEMS, 25, 20, -1, -1);
    wait_for_requests(1'b1);

    load_config(8'd255, 16'hFFFF, 7'd125, 16'hFFFF, 7'd125, 16'hFFFF, 7'd125);
    run_phase(PHASE_ITEMS, 30, 90, 80, -1);
    wait_for_requests(1'b1);

    load_random_config();
    run_phase(PHASE_ITEMS, 20, 50, -1, 120);
    wait_for_requests(1'b1);

    load_random_config();
    run_phase(PHASE_ITEMS, 40, 10, 150, -1);
    wait_for_requests(1'b1);

    load_random_config();
    run_phase(PHASE_ITEMS, 15, 70, -1, -1);
    wait_for_requests(1'b1);

    load_random_config();
    run_phase(PHASE_ITEMS, 25, 50, -1, 60);
    wait_for_requests(1'b1);

    $display("Run covered %0d items and %0d requests over %0d register settings.",
             items_sent, sb.requests_seen, config_sets);
    $display("Ticks that found every remaining slave in backoff: %0d, backoff releases: %0d.",
             sb.empty_walks, sb.releases);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d requests still outstanding.", sb.errors, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d requests outstanding.", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mps_pkg.sv
rtl/mps_ctrl.sv
rtl/mps_datapath.sv
rtl/modbus_poll_scheduler.sv
test/tb_modbus_poll_scheduler.sv
